// ===== src/cbyp_pkg.sv =====
// shared constants and types for the camera basis block
// no dependencies; imported by cbyp_sine_rom, camera_basis_from_yaw_pitch and tb_top
`timescale 1ns / 1ps

package cbyp_pkg;

    // item kind carried on s_tuser
    typedef enum logic {
        KIND_REL = 1'b0,
        KIND_ABS = 1'b1
    } kind_t;

    // width of each basis vector component on the result bus
    localparam int VEC_BITS = 16;

    // pi/2 in Q30, used to build the quarter-wave sine table
    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

    // taylor series for the table: number of terms and the divisor (2n+2)(2n+3) of each
    localparam int TAYLOR_TERMS = 12;
    localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
    };

endpackage

// ===== src/cbyp_sine_rom.sv =====
// quarter-wave sine rom with two registered read ports
// depends on cbyp_pkg for the taylor constants used to fill the table
`timescale 1ns / 1ps

module cbyp_sine_rom
    import cbyp_pkg::*;
#(
    parameter int ADDR_BITS = 10,
    parameter int FRAC_BITS = 15
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [ADDR_BITS:0]   addr_a,
    input  logic [ADDR_BITS:0]   addr_b,
    output logic [FRAC_BITS-1:0] data_a,
    output logic [FRAC_BITS-1:0] data_b
);

    localparam int DEPTH = (1 << ADDR_BITS) + 1;

    typedef logic [FRAC_BITS-1:0] rom_t [DEPTH];

    // entry k = sin(k * pi / 2^(ADDR_BITS+1)) in Q.FRAC_BITS, rounded half up, saturated
    function automatic rom_t build_rom();
        rom_t              r;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint unsigned   rv;
        longint unsigned   one;
        longint unsigned   maxv;
        longint            sum;
        one  = 64'd1 << 30;
        maxv = (64'd1 << FRAC_BITS) - 64'd1;
        for (int k = 0; k < DEPTH; k++) begin
            x = (longint'(k) * PI_HALF_Q30 + (64'd1 << (ADDR_BITS - 1))) >> ADDR_BITS;
            x2 = (x * x) >> 30;
            term = x;
            sum = longint'(x);
            for (int n = 0; n < TAYLOR_TERMS; n++) begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[n];
                if (n % 2 == 1) begin
                    sum = sum + longint'(term);
                end else begin
                    sum = sum - longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            if (longint'(one) < sum) begin
                sum = longint'(one);
            end
            rv = ((longint'(sum) << FRAC_BITS) + (64'd1 << 29)) >> 30;
            if (rv > maxv) begin
                rv = maxv;
            end
            r[k] = FRAC_BITS'(rv);
        end
        return r;
    endfunction

    localparam rom_t ROM = build_rom();

    logic [FRAC_BITS-1:0] data_a_reg;
    logic [FRAC_BITS-1:0] data_b_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            data_a_reg <= ROM[addr_a];
            data_b_reg <= ROM[addr_b];
        end
    end

    assign data_a = data_a_reg;
    assign data_b = data_b_reg;

endmodule

// ===== src/camera_basis_from_yaw_pitch.sv =====
// top level: camera angle tracker and orthonormal basis generator
// depends on cbyp_pkg and cbyp_sine_rom
`timescale 1ns / 1ps

// Camera basis from yaw and pitch. Each item on the slave stream either adds
// pitch and yaw deltas to the stored angles (tuser = 0) or sets them outright
// (tuser = 1). Angles are in 2^-ANGLE_FRAC_BITS degree. Relative pitch is
// clamped to +-89 degrees, absolute pitch to +-89.999 degrees, and yaw is
// wrapped into [-180, +180) degrees. Every item yields one result with the
// new angles and the right, up and back vectors in Q1.15. The block takes one
// item per clock unless the output stalls. The accepting edge loads the input
// register; behind it come the angle update, the phase multiplier, the
// registered sine rom read, the basis products and the sign and pack output
// register, which drives m_tvalid. Each stage has its own valid bit so empty
// slots close up while the output waits. The sine table is a constant rom, no
// clearing pass after reset.

module camera_basis_from_yaw_pitch
    import cbyp_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS      = 10,
    parameter int BASIS_FRAC_BITS      = 15,
    parameter int SINE_TABLE_ADDR_BITS = 10,
    localparam int IW = ANGLE_FRAC_BITS + 9,
    localparam int PW = ANGLE_FRAC_BITS + 8,
    localparam int YW = ANGLE_FRAC_BITS + 9,
    localparam int S_TDATA_W = ((2 * IW + 7) / 8) * 8,
    localparam int OW = PW + YW + 9 * VEC_BITS,
    localparam int M_TDATA_W = ((OW + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // slave side: angle update items
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // pitch_in, yaw_in
    input  logic [0:0]           s_tuser,   // kind
    // master side: angles and basis
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // pitch_out, yaw_out, right_x, right_y,
                                            // right_z, up_x, up_y, up_z, back_x,
                                            // back_y, back_z
);

    // ------------------------------------------------------------------
    // widths and constants
    // ------------------------------------------------------------------
    localparam int SW   = ANGLE_FRAC_BITS + 10;  // pitch sum
    localparam int TW   = ANGLE_FRAC_BITS + 11;  // yaw sum plus half turn
    localparam int AW   = ANGLE_FRAC_BITS + 9;   // angle reduced into [0, 360)
    localparam int NUMW = ANGLE_FRAC_BITS + SINE_TABLE_ADDR_BITS + 13;
    localparam int NW   = SINE_TABLE_ADDR_BITS + 8;  // scaled phase numerator
    localparam int SH   = NW + 6;                    // reciprocal shift for /45
    localparam int MW   = NW + 1;
    localparam int PRW  = NW + MW;
    localparam int PHW  = SINE_TABLE_ADDR_BITS + 2;  // phase, four quadrants
    localparam int IXW  = SINE_TABLE_ADDR_BITS + 1;  // table index 0..Q
    localparam int BF   = BASIS_FRAC_BITS;
    localparam int MAGW = BF + 1;
    localparam int XW   = (BF + 2 > VEC_BITS) ? BF + 2 : VEC_BITS;
    localparam int NSTG = 6;

    localparam int FULL = 360 << ANGLE_FRAC_BITS;
    localparam int HALF = 180 << ANGLE_FRAC_BITS;
    localparam int QTR  = 1 << SINE_TABLE_ADDR_BITS;

    localparam logic signed [SW-1:0] LIM_REL = SW'(89 << ANGLE_FRAC_BITS);
    localparam logic signed [SW-1:0] LIM_ABS = SW'((89999 << ANGLE_FRAC_BITS) / 1000);
    localparam logic signed [TW-1:0] FULL_T  = TW'(FULL);
    localparam logic signed [TW-1:0] HALF_T  = TW'(HALF);
    localparam logic signed [AW:0]   FULL_A  = (AW + 1)'(FULL);
    localparam logic signed [YW-1:0] HALF_Y  = YW'(HALF);

    // phase = floor(num / (720 * 2^AF)); num >> (AF+4) then divide by 45
    localparam longint MRECIP = ((64'd1 << SH) + 64'd44) / 64'd45;
    localparam logic [MW-1:0] M_RECIP = MW'(MRECIP);

    // ------------------------------------------------------------------
    // stage handshake: each stage moves when it is empty or the next one moves
    // ------------------------------------------------------------------
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] en;

    always_comb begin
        en[NSTG-1] = !vld_reg[NSTG-1] || m_tready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (en[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = vld_reg[NSTG-1];

    // ------------------------------------------------------------------
    // stage 0: input register
    // ------------------------------------------------------------------
    kind_t                 in_kind_reg;
    logic signed [IW-1:0]  in_pitch_reg;
    logic signed [IW-1:0]  in_yaw_reg;

    always_ff @(posedge aclk) begin
        if (en[0] && s_tvalid) begin
            in_kind_reg  <= kind_t'(s_tuser[0]);
            in_pitch_reg <= s_tdata[IW-1:0];
            in_yaw_reg   <= s_tdata[2*IW-1:IW];
        end
    end

    // ------------------------------------------------------------------
    // stage 1: angle update; these registers are the camera state
    // ------------------------------------------------------------------
    logic signed [PW-1:0]  pitch_angle_reg;
    logic signed [YW-1:0]  yaw_angle_reg;
    logic signed [PW-1:0]  pitch_angle_next;
    logic signed [YW-1:0]  yaw_angle_next;
    logic signed [SW-1:0]  p_sum;
    logic signed [SW-1:0]  p_lim;
    logic signed [TW-1:0]  y_sum;
    logic signed [TW-1:0]  y_t;
    logic                  ld1;

    assign ld1 = en[1] && vld_reg[0];

    always_comb begin
        if (in_kind_reg == KIND_ABS) begin
            p_sum = SW'(in_pitch_reg);
            y_sum = TW'(in_yaw_reg);
            p_lim = LIM_ABS;
        end else begin
            p_sum = SW'(pitch_angle_reg) + SW'(in_pitch_reg);
            y_sum = TW'(yaw_angle_reg) + TW'(in_yaw_reg);
            p_lim = LIM_REL;
        end
        // clamp pitch symmetric about level
        if (p_sum > p_lim) begin
            p_sum = p_lim;
        end else if (p_sum < -p_lim) begin
            p_sum = -p_lim;
        end
        pitch_angle_next = PW'(p_sum);
        // wrap yaw into [-180, 180): one correction covers the input range
        y_t = y_sum + HALF_T;
        if (y_t < 0) begin
            y_t = y_t + FULL_T;
        end else if (y_t >= FULL_T) begin
            y_t = y_t - FULL_T;
        end
        yaw_angle_next = YW'(y_t - HALF_T);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pitch_angle_reg <= '0;
            yaw_angle_reg   <= '0;
        end else if (ld1) begin
            pitch_angle_reg <= pitch_angle_next;
            yaw_angle_reg   <= yaw_angle_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: phase numerator times reciprocal of 45
    // ------------------------------------------------------------------
    function automatic logic [PRW-1:0] phase_prod(input logic signed [AW-1:0] ang);
        logic signed [AW:0] ext;
        logic [NUMW-1:0]    num;
        logic [NW-1:0]      n2;
        ext = (AW + 1)'(ang);
        if (ext < 0) begin
            ext = ext + FULL_A;
        end
        num = (NUMW'(ext[AW-1:0]) << (SINE_TABLE_ADDR_BITS + 3)) + NUMW'(FULL);
        n2  = num[ANGLE_FRAC_BITS+4 +: NW];
        return PRW'(n2) * PRW'(M_RECIP);
    endfunction

    logic [PRW-1:0]        prod_p_reg;
    logic [PRW-1:0]        prod_y_reg;
    logic signed [PW-1:0]  pitch2_reg;
    logic signed [YW-1:0]  yaw2_reg;

    always_ff @(posedge aclk) begin
        if (en[2] && vld_reg[1]) begin
            prod_p_reg <= phase_prod(AW'(pitch_angle_reg));
            prod_y_reg <= phase_prod(AW'(yaw_angle_reg));
            pitch2_reg <= pitch_angle_reg;
            yaw2_reg   <= yaw_angle_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: quadrant fold and registered table read
    // ------------------------------------------------------------------
    function automatic logic [IXW-1:0] fold_index(input logic [PHW-1:0] ph);
        logic [SINE_TABLE_ADDR_BITS-1:0] off;
        off = ph[SINE_TABLE_ADDR_BITS-1:0];
        if (ph[SINE_TABLE_ADDR_BITS]) begin
            return IXW'(QTR) - IXW'(off);
        end
        return IXW'(off);
    endfunction

    logic [PHW-1:0]        ph_sp;
    logic [PHW-1:0]        ph_cp;
    logic [PHW-1:0]        ph_sy;
    logic [PHW-1:0]        ph_cy;
    logic                  ld3;
    logic [BF-1:0]         mag_sp;
    logic [BF-1:0]         mag_cp;
    logic [BF-1:0]         mag_sy;
    logic [BF-1:0]         mag_cy;
    logic                  neg_sp_reg;
    logic                  neg_cp_reg;
    logic                  neg_sy_reg;
    logic                  neg_cy_reg;
    logic signed [PW-1:0]  pitch3_reg;
    logic signed [YW-1:0]  yaw3_reg;

    assign ph_sp = prod_p_reg[SH +: PHW];
    assign ph_sy = prod_y_reg[SH +: PHW];
    // cosine is the sine a quarter turn later
    assign ph_cp = ph_sp + PHW'(QTR);
    assign ph_cy = ph_sy + PHW'(QTR);
    assign ld3   = en[3] && vld_reg[2];

    cbyp_sine_rom #(
        .ADDR_BITS (SINE_TABLE_ADDR_BITS),
        .FRAC_BITS (BF)
    ) u_rom_pitch (
        .aclk   (aclk),
        .en     (ld3),
        .addr_a (fold_index(ph_sp)),
        .addr_b (fold_index(ph_cp)),
        .data_a (mag_sp),
        .data_b (mag_cp)
    );

    cbyp_sine_rom #(
        .ADDR_BITS (SINE_TABLE_ADDR_BITS),
        .FRAC_BITS (BF)
    ) u_rom_yaw (
        .aclk   (aclk),
        .en     (ld3),
        .addr_a (fold_index(ph_sy)),
        .addr_b (fold_index(ph_cy)),
        .data_a (mag_sy),
        .data_b (mag_cy)
    );

    // upper half of the turn gives a negative value
    always_ff @(posedge aclk) begin
        if (ld3) begin
            neg_sp_reg <= ph_sp[PHW-1];
            neg_cp_reg <= ph_cp[PHW-1];
            neg_sy_reg <= ph_sy[PHW-1];
            neg_cy_reg <= ph_cy[PHW-1];
            pitch3_reg <= pitch2_reg;
            yaw3_reg   <= yaw2_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: magnitude products, rounded half up
    // ------------------------------------------------------------------
    function automatic logic [MAGW-1:0] rmul(input logic [BF-1:0] a, input logic [BF-1:0] b);
        logic [2*BF-1:0] p;
        p = (2 * BF)'(a) * (2 * BF)'(b) + ((2 * BF)'(1) << (BF - 1));
        return MAGW'(p >> BF);
    endfunction

    logic [MAGW-1:0]       m_spcy_reg;
    logic [MAGW-1:0]       m_spsy_reg;
    logic [MAGW-1:0]       m_cycp_reg;
    logic [MAGW-1:0]       m_sycp_reg;
    logic [BF-1:0]         v_sp_reg;
    logic [BF-1:0]         v_cp_reg;
    logic [BF-1:0]         v_sy_reg;
    logic [BF-1:0]         v_cy_reg;
    logic                  n_sp_reg;
    logic                  n_cp_reg;
    logic                  n_sy_reg;
    logic                  n_cy_reg;
    logic signed [PW-1:0]  pitch4_reg;
    logic signed [YW-1:0]  yaw4_reg;

    always_ff @(posedge aclk) begin
        if (en[4] && vld_reg[3]) begin
            m_spcy_reg <= rmul(mag_sp, mag_cy);
            m_spsy_reg <= rmul(mag_sp, mag_sy);
            m_cycp_reg <= rmul(mag_cy, mag_cp);
            m_sycp_reg <= rmul(mag_sy, mag_cp);
            v_sp_reg   <= mag_sp;
            v_cp_reg   <= mag_cp;
            v_sy_reg   <= mag_sy;
            v_cy_reg   <= mag_cy;
            n_sp_reg   <= neg_sp_reg;
            n_cp_reg   <= neg_cp_reg;
            n_sy_reg   <= neg_sy_reg;
            n_cy_reg   <= neg_cy_reg;
            pitch4_reg <= pitch3_reg;
            yaw4_reg   <= yaw3_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: apply signs and pack the result
    // ------------------------------------------------------------------
    function automatic logic [VEC_BITS-1:0] signed_vec(input logic neg,
                                                       input logic [MAGW-1:0] mag);
        logic [XW-1:0] val;
        val = XW'(mag);
        if (neg) begin
            val = -val;
        end
        return val[VEC_BITS-1:0];
    endfunction

    logic [VEC_BITS-1:0]   right_x;
    logic [VEC_BITS-1:0]   right_y;
    logic [VEC_BITS-1:0]   right_z;
    logic [VEC_BITS-1:0]   up_x;
    logic [VEC_BITS-1:0]   up_y;
    logic [VEC_BITS-1:0]   up_z;
    logic [VEC_BITS-1:0]   back_x;
    logic [VEC_BITS-1:0]   back_y;
    logic [VEC_BITS-1:0]   back_z;
    logic [M_TDATA_W-1:0]  m_tdata_reg;
    logic [M_TDATA_W-1:0]  m_tdata_next;

    always_comb begin
        // right = (-sy, 0, cy)
        right_x = signed_vec(!n_sy_reg, MAGW'(v_sy_reg));
        right_y = '0;
        right_z = signed_vec(n_cy_reg, MAGW'(v_cy_reg));
        // up = (-sp*cy, cp, -sp*sy)
        up_x    = signed_vec(!(n_sp_reg ^ n_cy_reg), m_spcy_reg);
        up_y    = signed_vec(n_cp_reg, MAGW'(v_cp_reg));
        up_z    = signed_vec(!(n_sp_reg ^ n_sy_reg), m_spsy_reg);
        // back = (-cy*cp, -sp, -sy*cp)
        back_x  = signed_vec(!(n_cy_reg ^ n_cp_reg), m_cycp_reg);
        back_y  = signed_vec(!n_sp_reg, MAGW'(v_sp_reg));
        back_z  = signed_vec(!(n_sy_reg ^ n_cp_reg), m_sycp_reg);

        m_tdata_next = '0;
        m_tdata_next[OW-1:0] = {back_z, back_y, back_x, up_z, up_y, up_x,
                                right_z, right_y, right_x, yaw4_reg, pitch4_reg};
    end

    always_ff @(posedge aclk) begin
        if (en[5] && vld_reg[4]) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tdata = m_tdata_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // camera state changes only when an item moves into the update stage
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !ld1 |=> $stable(pitch_angle_reg) && $stable(yaw_angle_reg))
        else $error("camera state changed without an item");

    // stored pitch never leaves the absolute clamp
    a_pitch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (SW'(pitch_angle_reg) <= LIM_ABS) && (SW'(pitch_angle_reg) >= -LIM_ABS))
        else $error("pitch outside clamp range");

    // stored yaw stays in the half-open range [-180, 180) degrees
    a_yaw_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (yaw_angle_reg >= -HALF_Y) && (yaw_angle_reg < HALF_Y))
        else $error("yaw outside wrap range");

    // input is refused only when every stage holds an item
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (&vld_reg))
        else $error("input stalled with an empty stage");

endmodule

// ===== tb/tb_top.sv =====
// self-checking bench for camera_basis_from_yaw_pitch: directed rows, then random items
// keeps its own angle state and sine table to predict each frame; needs cbyp_pkg and the rtl
`timescale 1ns / 1ps

module tb_top;
    import cbyp_pkg::*;

    // block geometry at default parameters
    localparam int ANG_FRAC   = 10;
    localparam int BASIS_FRAC = 15;
    localparam int TAB_BITS   = 10;
    localparam int QUARTER    = 1 << TAB_BITS;
    localparam int FULL_TURN  = 360 << ANG_FRAC;
    localparam int HALF_TURN  = 180 << ANG_FRAC;
    localparam int REL_PITCH_LIM = 89 << ANG_FRAC;
    localparam int ABS_PITCH_LIM = (89999 << ANG_FRAC) / 1000;
    localparam int ONE_Q15       = (1 << BASIS_FRAC) - 1;

    localparam int RANDOM_PER_PHASE = 300;
    localparam int DRAIN_CYCLES     = 12;
    localparam int CYCLE_LIMIT      = 200000;

    // one result frame, laid out as on m_tdata (pitch in the lowest bits)
    typedef struct packed {
        logic signed [15:0] back_z;
        logic signed [15:0] back_y;
        logic signed [15:0] back_x;
        logic signed [15:0] up_z;
        logic signed [15:0] up_y;
        logic signed [15:0] up_x;
        logic signed [15:0] right_z;
        logic signed [15:0] right_y;
        logic signed [15:0] right_x;
        logic signed [18:0] yaw;
        logic signed [17:0] pitch;
    } camera_frame_t;

    localparam int FRAME_W = $bits(camera_frame_t);

    // one directed row; want is used only where typed is set
    typedef struct packed {
        kind_t              kind;
        logic signed [18:0] pitch;
        logic signed [18:0] yaw;
        logic               typed;
        camera_frame_t      want;
    } script_row_t;

    // frames that can be read straight off the closed form
    localparam camera_frame_t NO_FRAME = '0;
    // level camera looking along +x (back along -x), right along +z
    localparam camera_frame_t LEVEL_FRAME = '{
        pitch: 18'sd0, yaw: 19'sd0,
        right_x: 16'sd0, right_y: 16'sd0, right_z: 16'sd32767,
        up_x: 16'sd0, up_y: 16'sd32767, up_z: 16'sd0,
        back_x: -16'sd32766, back_y: 16'sd0, back_z: 16'sd0};
    // yaw of +90 degrees
    localparam camera_frame_t YAW_90_FRAME = '{
        pitch: 18'sd0, yaw: 19'sd92160,
        right_x: -16'sd32767, right_y: 16'sd0, right_z: 16'sd0,
        up_x: 16'sd0, up_y: 16'sd32767, up_z: 16'sd0,
        back_x: 16'sd0, back_y: 16'sd0, back_z: -16'sd32766};
    // yaw of exactly -180 degrees, the low end of the wrap range
    localparam camera_frame_t YAW_180_FRAME = '{
        pitch: 18'sd0, yaw: -19'sd184320,
        right_x: 16'sd0, right_y: 16'sd0, right_z: -16'sd32767,
        up_x: 16'sd0, up_y: 16'sd32767, up_z: 16'sd0,
        back_x: 16'sd32766, back_y: 16'sd0, back_z: 16'sd0};

    localparam int SCRIPT_LEN = 22;
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        // state after reset, nothing added
        '{KIND_REL, 19'sd0, 19'sd0, 1'b1, LEVEL_FRAME},
        '{KIND_ABS, 19'sd0, 19'sd92160, 1'b1, YAW_90_FRAME},
        '{KIND_ABS, 19'sd0, -19'sd184320, 1'b1, YAW_180_FRAME},
        // field extremes, absolute pitch clamp on both sides
        '{KIND_ABS, 19'sd184319, 19'sd184319, 1'b0, NO_FRAME},
        '{KIND_ABS, -19'sd184320, -19'sd184320, 1'b0, NO_FRAME},
        // relative item pulls a pitch beyond 89 degrees back in
        '{KIND_REL, 19'sd0, 19'sd0, 1'b0, NO_FRAME},
        '{KIND_ABS, 19'sd92158, 19'sd0, 1'b0, NO_FRAME},
        '{KIND_ABS, 19'sd92159, -19'sd1, 1'b0, NO_FRAME},
        '{KIND_REL, 19'sd1, 19'sd1, 1'b0, NO_FRAME},
        '{KIND_REL, -19'sd1, 19'sd0, 1'b0, NO_FRAME},
        // yaw wrap across +180 and back
        '{KIND_ABS, 19'sd91136, 19'sd184000, 1'b0, NO_FRAME},
        '{KIND_REL, 19'sd0, 19'sd400, 1'b0, NO_FRAME},
        '{KIND_REL, 19'sd0, -19'sd400, 1'b0, NO_FRAME},
        // largest relative steps both ways
        '{KIND_REL, -19'sd184320, -19'sd184320, 1'b0, NO_FRAME},
        '{KIND_REL, 19'sd184319, 19'sd184319, 1'b0, NO_FRAME},
        '{KIND_ABS, -19'sd92158, -19'sd92160, 1'b0, NO_FRAME},
        '{KIND_ABS, -19'sd92159, 19'sd1, 1'b0, NO_FRAME},
        // ordinary angles in several quadrants
        '{KIND_ABS, 19'sd46080, 19'sd30720, 1'b0, NO_FRAME},
        '{KIND_ABS, -19'sd46080, -19'sd153600, 1'b0, NO_FRAME},
        '{KIND_REL, 19'sd512, -19'sd512, 1'b0, NO_FRAME},
        '{KIND_ABS, 19'sd1, 19'sd1, 1'b0, NO_FRAME},
        '{KIND_ABS, -19'sd1, -19'sd1, 1'b0, NO_FRAME}
    };

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [39:0]  s_tdata  = '0;   // pitch_in, yaw_in
    logic [0:0]   s_tuser  = '0;   // kind
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [183:0] m_tdata;         // pitch_out, yaw_out, right_x, right_y, right_z,
                                   // up_x, up_y, up_z, back_x, back_y, back_z

    // predictor state and the frames still owed by the block
    int            cam_pitch = 0;
    int            cam_yaw   = 0;
    int            quarter_wave [0:QUARTER];
    camera_frame_t frames_due [$];

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int errors        = 0;
    int cycle_count   = 0;

    camera_basis_from_yaw_pitch uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // quarter-wave entry k: taylor series of sin in q30, rounded half up to q15
    function automatic int quarter_wave_entry(int k);
        longint unsigned x, x2, term, ku;
        longint          sum, r;
        ku = longint'(k);
        x = (ku * PI_HALF_Q30 + 64'd512) >> TAB_BITS;
        x2 = (x * x) >> 30;
        term = x;
        sum = longint'(x);
        for (int n = 0; n < 12; n++) begin
            term = ((term * x2) >> 30) / longint'((2 * n + 2) * (2 * n + 3));
            if (n % 2 == 1)
                sum += longint'(term);
            else
                sum -= longint'(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > (64'sd1 << 30))
            sum = 64'sd1 << 30;
        r = ((sum << BASIS_FRAC) + (64'sd1 << 29)) >>> 30;
        if (r > ONE_Q15)
            r = ONE_Q15;
        return int'(r);
    endfunction

    function automatic longint wrap_mod(longint x, longint m);
        longint r;
        r = x % m;
        if (r < 0)
            r += m;
        return r;
    endfunction

    // angle to table phase, rounded to nearest step
    function automatic int phase_of(int angle);
        longint a;
        a = wrap_mod(angle, FULL_TURN);
        return int'((a * (8 * QUARTER) + FULL_TURN) / (2 * FULL_TURN));
    endfunction

    // quadrant symmetry over the quarter-wave table
    function automatic int sine_at(int phase);
        int p, quad, off, v;
        p = phase & (4 * QUARTER - 1);
        quad = p >> TAB_BITS;
        off = p & (QUARTER - 1);
        v = (quad & 1) ? quarter_wave[QUARTER - off] : quarter_wave[off];
        return (quad & 2) ? -v : v;
    endfunction

    // q15 product rounded on magnitudes, so symmetric about zero
    function automatic int q15_mul(int a, int b);
        longint ma, mb, m;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        m = (ma * mb + (64'sd1 << (BASIS_FRAC - 1))) >>> BASIS_FRAC;
        return ((a < 0) != (b < 0)) ? -int'(m) : int'(m);
    endfunction

    // apply one item to the camera angles and build the frame it should yield
    function automatic camera_frame_t advance_camera(kind_t kind, int pitch_in, int yaw_in);
        int            lim, p, y, pp, py, sp, cp, sy, cy;
        camera_frame_t f;
        if (kind == KIND_ABS) begin
            lim = ABS_PITCH_LIM;
            p = pitch_in;
            y = yaw_in;
        end else begin
            lim = REL_PITCH_LIM;
            p = cam_pitch + pitch_in;
            y = cam_yaw + yaw_in;
        end
        if (p > lim)
            p = lim;
        if (p < -lim)
            p = -lim;
        y = int'(wrap_mod(y + HALF_TURN, FULL_TURN)) - HALF_TURN;
        cam_pitch = p;
        cam_yaw = y;
        pp = phase_of(p);
        py = phase_of(y);
        sp = sine_at(pp);
        cp = sine_at(pp + QUARTER);
        sy = sine_at(py);
        cy = sine_at(py + QUARTER);
        f.pitch   = 18'(p);
        f.yaw     = 19'(y);
        f.right_x = 16'(-sy);
        f.right_y = 16'sd0;
        f.right_z = 16'(cy);
        f.up_x    = 16'(-q15_mul(sp, cy));
        f.up_y    = 16'(cp);
        f.up_z    = 16'(-q15_mul(sp, sy));
        f.back_x  = 16'(-q15_mul(cy, cp));
        f.back_y  = 16'(-sp);
        f.back_z  = 16'(-q15_mul(sy, cp));
        return f;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    task automatic check_frame(input camera_frame_t got, input camera_frame_t want);
        check_field("pitch_out", want.pitch, got.pitch);
        check_field("yaw_out", want.yaw, got.yaw);
        check_field("right_x", want.right_x, got.right_x);
        check_field("right_y", want.right_y, got.right_y);
        check_field("right_z", want.right_z, got.right_z);
        check_field("up_x", want.up_x, got.up_x);
        check_field("up_y", want.up_y, got.up_y);
        check_field("up_z", want.up_z, got.up_z);
        check_field("back_x", want.back_x, got.back_x);
        check_field("back_y", want.back_y, got.back_y);
        check_field("back_z", want.back_z, got.back_z);
    endtask

    // present one item, hold it until taken, then record the frame it owes
    task automatic send_item(input kind_t kind, input int pitch_in, input int yaw_in,
                             input logic typed, input camera_frame_t want);
        camera_frame_t predicted;
        // random gaps before the item; valid only ever changes once per edge
        while (int'($urandom_range(99)) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'b00, 19'(yaw_in), 19'(pitch_in)};
        do
            @(posedge aclk);
        while (!s_tready);
        // predictor runs on every item so its state follows the block
        predicted = advance_camera(kind, pitch_in, yaw_in);
        frames_due.push_back(typed ? want : predicted);
    endtask

    // random item mix: small relative moves most often, plenty of clamps and wraps
    task automatic pick_random_item(output kind_t kind, output int pitch_in,
                                    output int yaw_in);
        int mix;
        mix = int'($urandom_range(99));
        if (mix < 40) begin
            // small mouse-like deltas
            kind = KIND_REL;
            pitch_in = int'($urandom_range(8192)) - 4096;
            yaw_in = int'($urandom_range(16384)) - 8192;
        end else if (mix < 55) begin
            // relative, whole field range
            kind = KIND_REL;
            pitch_in = int'($urandom_range(368639)) - 184320;
            yaw_in = int'($urandom_range(368639)) - 184320;
        end else if (mix < 80) begin
            // absolute, whole field range
            kind = KIND_ABS;
            pitch_in = int'($urandom_range(368639)) - 184320;
            yaw_in = int'($urandom_range(368639)) - 184320;
        end else if (mix < 90) begin
            // absolute near the pitch limits, yaw on or one step past a quarter turn
            kind = KIND_ABS;
            pitch_in = int'($urandom_range(92160, 91134));
            if ($urandom_range(1) == 1)
                pitch_in = -pitch_in;
            yaw_in = int'($urandom_range(3)) * 92160 - HALF_TURN + int'($urandom_range(1));
        end else begin
            // relative push into the 89 degree clamp
            kind = KIND_REL;
            pitch_in = int'($urandom_range(40000, 1000));
            if ($urandom_range(1) == 1)
                pitch_in = -pitch_in;
            yaw_in = int'($urandom_range(2)) - 1;
        end
    endtask

    // receiver stall pattern
    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= (int'($urandom_range(99)) >= sink_idle_pct);
    end

    // compare each accepted frame with the oldest one owed
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (frames_due.size() == 0) begin
                $error("result item with no item pending");
                errors++;
            end else begin
                check_frame(camera_frame_t'(m_tdata[FRAME_W-1:0]), frames_due.pop_front());
            end
        end
    end

    // hard stop if the block hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        kind_t rnd_kind;
        int    rnd_pitch, rnd_yaw;
        int    src_pcts  [3];
        int    sink_pcts [3];
        src_pcts  = '{30, 67, 0};
        sink_pcts = '{67, 30, 0};
        for (int k = 0; k <= QUARTER; k++)
            quarter_wave[k] = quarter_wave_entry(k);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed rows run under the first idling pattern
        src_idle_pct  = src_pcts[0];
        sink_idle_pct = sink_pcts[0];
        for (int r = 0; r < SCRIPT_LEN; r++)
            send_item(SCRIPT[r].kind, SCRIPT[r].pitch, SCRIPT[r].yaw,
                      SCRIPT[r].typed, SCRIPT[r].want);

        // random items: receiver-slow, then sender-slow, then full rate
        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct  = src_pcts[ph];
            sink_idle_pct = sink_pcts[ph];
            for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
                pick_random_item(rnd_kind, rnd_pitch, rnd_yaw);
                send_item(rnd_kind, rnd_pitch, rnd_yaw, 1'b0, NO_FRAME);
            end
        end
        s_tvalid <= 1'b0;

        // let the pipe empty, then watch a little longer for stray items
        while (frames_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
